[rtl/lpe_pkg.sv]
// lpe_pkg: shared types and constants for the legendre polynomial evaluator
`timescale 1ns / 1ps

package lpe_pkg;

  localparam int DEG_W      = 8;
  localparam int X_W        = 18;
  localparam int OUT_W      = 18;
  localparam int ST_W       = 2;
  localparam int RECIP_BITS = 22;
  localparam int R_W        = RECIP_BITS + 1;

  typedef enum logic [ST_W-1:0] {
    ST_OK  = 2'd0,
    ST_NEG = 2'd1,
    ST_BIG = 2'd2
  } status_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_XP   = 6'b000010,
    S_CM   = 6'b000100,
    S_RC   = 6'b001000,
    S_FIN  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

endpackage

[rtl/lpe_if.sv]
// lpe_if: valid/ready channel interfaces for items and results
`timescale 1ns / 1ps

interface lpe_in_if import lpe_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [DEG_W-1:0] degree;
  logic signed [X_W-1:0]   x_value;

  modport source (output valid, degree, x_value, input ready);
  modport sink   (input valid, degree, x_value, output ready);
endinterface

interface lpe_out_if import lpe_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] poly_value;
  logic        [ST_W-1:0]  status;

  modport source (output valid, poly_value, status, input ready);
  modport sink   (input valid, poly_value, status, output ready);
endinterface

[rtl/lpe_recip_rom.sv]
// lpe_recip_rom: constant table of rounded reciprocals 2^RECIP_BITS / k, zero for k below 2
`timescale 1ns / 1ps

module lpe_recip_rom import lpe_pkg::*; #(
  parameter int MAX_DEGREE = 63
) (
  input  logic [$clog2(MAX_DEGREE+1)-1:0] k,
  output logic signed [R_W-1:0]           recip
);

  logic [R_W-1:0] tab [0:MAX_DEGREE];

  for (genvar g = 0; g <= MAX_DEGREE; g++) begin : g_tab
    localparam int Div = (g < 2) ? 1 : g;
    localparam int Rv  = (g < 2) ? 0 : (((1 << RECIP_BITS) + Div / 2) / Div);
    assign tab[g] = R_W'(Rv);
  end

  // depths that are not a power of two leave unused codes
  assign recip = (int'(k) > MAX_DEGREE) ? '0 : $signed(tab[k]);

endmodule

[rtl/lpe_mul.sv]
// lpe_mul: shared signed multiplier with registered product
`timescale 1ns / 1ps

module lpe_mul #(
  parameter int AW = 27,
  parameter int BW = 23
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [AW-1:0]     a,
  input  logic signed [BW-1:0]     b,
  output logic signed [AW+BW-1:0]  prod_r
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * b;
    end
  end

endmodule

[rtl/legendre_polynomial_eval.sv]
// legendre_polynomial_eval: top level, sequencer and datapath around the shared multiplier
//
// Evaluates P_d(x) in signed fixed point with FRAC_BITS fraction bits.
// in_ch carries one word of degree and x_value; out_ch returns one word of
// poly_value and status (ok, negative degree, degree above MAX_DEGREE).
// x is clamped to plus or minus one before use.
// Degrees 0 and 1 and error cases go from idle straight to the done state,
// which then raises out_ch.valid. For d >= 2 Bonnet's recurrence runs d-1
// steps, each through S_XP, S_CM and S_RC on the one shared multiplier
// (x*P_c, c*(2t-P_{c-1}), num*recip), then S_FIN takes the last value.
// With the output free the sequencer returns to idle as out_ch.valid rises,
// so the next word can be taken while the result waits.
// in_ch.ready is high only while the sequencer is idle, so one item is in
// work at a time; the result sits in an output register, and the next item
// is taken while it waits.
// If out_ch.ready stays low, a second finished result holds in the done
// state until the output register frees, and no new item is taken.
// Reset (rst_n low, synchronous) returns the sequencer to idle and empties
// the output register.
`timescale 1ns / 1ps

module legendre_polynomial_eval import lpe_pkg::*; #(
  parameter int MAX_DEGREE = 63,
  parameter int FRAC_BITS  = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  lpe_in_if.sink   in_ch,
  lpe_out_if.source out_ch
);

  localparam int PW  = FRAC_BITS + 2;
  localparam int CW  = (PW > X_W) ? PW : X_W;
  localparam int AW  = FRAC_BITS + 11;
  localparam int BW  = R_W;
  localparam int PRW = AW + BW;
  localparam int OW  = (PW > OUT_W) ? PW : OUT_W;
  localparam int KW  = $clog2(MAX_DEGREE + 1);

  localparam logic signed [CW-1:0]  ONE_CW = CW'(1) << FRAC_BITS;
  localparam logic signed [PW-1:0]  ONE_PW = PW'(1) << FRAC_BITS;
  localparam logic signed [PRW-1:0] ONE_PR = PRW'(1) << FRAC_BITS;
  localparam logic signed [PRW-1:0] HALF_F = PRW'(1) << (FRAC_BITS - 1);
  localparam logic signed [PRW-1:0] HALF_R = PRW'(1) << (RECIP_BITS - 1);

  state_t                 state_r, state_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic signed [OUT_W-1:0] poly_r;
  status_t                st_out_r;

  logic signed [X_W-1:0]  x_r;
  logic signed [PW-1:0]   cur_r, prev_r, t_r;
  logic [KW-1:0]          c_r, deg_r;
  logic                   first_r;
  status_t                st_r;

  logic                   in_acc, out_free, last_step, direct;
  logic                   deg_neg, deg_big;
  status_t                st_in;
  logic signed [CW-1:0]   x_ext, x_clamp;
  logic signed [PRW-1:0]  prod_r, rt, rn;
  logic signed [PW-1:0]   t_w, nxt, cur_in, cur_direct;
  logic signed [PW:0]     diff;
  logic signed [AW-1:0]   num, mul_a;
  logic signed [BW-1:0]   mul_b;
  logic signed [R_W-1:0]  recip;
  logic [KW-1:0]          k_w;
  logic signed [OW-1:0]   cur_ow;
  logic                   mul_en;

  // handshakes
  assign in_ch.ready       = (state_r == S_IDLE);
  assign in_acc            = in_ch.valid && in_ch.ready;
  assign out_free          = !out_valid_r || out_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.poly_value = poly_r;
  assign out_ch.status     = st_out_r;

  // input decode and clamp
  assign deg_neg = in_ch.degree[DEG_W-1];
  assign deg_big = (int'(in_ch.degree) > MAX_DEGREE);
  assign x_ext   = CW'(in_ch.x_value);

  always_comb begin
    if (x_ext > ONE_CW) begin
      x_clamp = ONE_CW;
    end else if (x_ext < -ONE_CW) begin
      x_clamp = -ONE_CW;
    end else begin
      x_clamp = x_ext;
    end
  end

  always_comb begin
    st_in      = ST_OK;
    cur_direct = x_clamp[PW-1:0];
    if (deg_neg) begin
      st_in      = ST_NEG;
      cur_direct = '0;
    end else if (deg_big) begin
      st_in      = ST_BIG;
      cur_direct = '0;
    end else if (in_ch.degree == '0) begin
      cur_direct = ONE_PW;
    end
  end

  assign direct = deg_neg || deg_big || (in_ch.degree[DEG_W-1:1] == '0);

  // rounding of the registered product
  assign rt  = $signed(prod_r + HALF_F) >>> FRAC_BITS;
  assign t_w = rt[PW-1:0];
  assign rn  = $signed(prod_r + HALF_R) >>> RECIP_BITS;

  // each new value is saturated to plus or minus one
  always_comb begin
    if (rn > ONE_PR) begin
      nxt = ONE_PW;
    end else if (rn < -ONE_PR) begin
      nxt = -ONE_PW;
    end else begin
      nxt = rn[PW-1:0];
    end
  end

  assign cur_in    = first_r ? cur_r : nxt;
  assign diff      = {t_w, 1'b0} - {prev_r[PW-1], prev_r};
  assign num       = prod_r[AW-1:0] + AW'(t_r);
  assign k_w       = c_r + KW'(1);
  assign last_step = (k_w == deg_r);
  assign cur_ow    = OW'(cur_r);

  lpe_recip_rom #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_rom (
    .k     (k_w),
    .recip (recip)
  );

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_XP: begin
        mul_a = AW'(cur_in);
        mul_b = BW'(x_r);
      end
      S_CM: begin
        mul_a = AW'(diff);
        mul_b = $signed({{(BW-KW){1'b0}}, c_r});
      end
      S_RC: begin
        mul_a = num;
        mul_b = recip;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_en = state_r inside {S_XP, S_CM, S_RC};

  lpe_mul #(
    .AW (AW),
    .BW (BW)
  ) u_mul (
    .clk    (clk),
    .en     (mul_en),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = direct ? S_DONE : S_XP;
        end
      end
      S_XP:   state_nxt = S_CM;
      S_CM:   state_nxt = S_RC;
      S_RC:   state_nxt = last_step ? S_FIN : S_XP;
      S_FIN:  state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if ((state_r == S_DONE) && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // recurrence registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          x_r     <= x_clamp[X_W-1:0];
          deg_r   <= in_ch.degree[KW-1:0];
          c_r     <= KW'(1);
          first_r <= 1'b1;
          prev_r  <= ONE_PW;
          cur_r   <= cur_direct;
          st_r    <= st_in;
        end
      end
      S_XP: begin
        cur_r <= cur_in;
        if (!first_r) begin
          prev_r <= cur_r;
        end
      end
      S_CM: begin
        t_r <= t_w;
      end
      S_RC: begin
        c_r     <= k_w;
        first_r <= 1'b0;
      end
      S_FIN: begin
        cur_r <= nxt;
      end
      default: begin
      end
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && out_free) begin
      poly_r   <= cur_ow[OUT_W-1:0];
      st_out_r <= st_r;
    end
  end

endmodule

[rtl/lpe_checker.sv]
// lpe_checker: port-level assertions for the evaluator and their bind
`timescale 1ns / 1ps

module lpe_checker import lpe_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [OUT_W-1:0] poly_value,
  input logic        [ST_W-1:0]  status
);

  // one word in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a word is in work");

  // an error result carries a zero value
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (status == ST_NEG || status == ST_BIG)) |-> (poly_value == '0))
    else $error("error result with non-zero value");

  // a fresh result only appears after the sequencer has been busy
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared with no word in work");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(poly_value) && $stable(status)))
    else $error("stalled result changed");

endmodule

bind legendre_polynomial_eval lpe_checker u_lpe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .poly_value (out_ch.poly_value),
  .status     (out_ch.status)
);

[tb/sv/legendre_polynomial_eval_tb.sv]
// legendre_polynomial_eval_tb: self-checking bench for the legendre polynomial evaluator
`timescale 1ns / 1ps

module legendre_polynomial_eval_tb import lpe_pkg::*;;

  localparam int  MAX_DEG      = 63;
  localparam int  FRAC         = 16;
  localparam int  ONE          = 1 << FRAC;
  localparam int  GAP_MAX      = 18;
  localparam int  DRAIN_CYCLES = 200;
  localparam int  CYCLE_LIMIT  = 1000000;

  typedef struct {
    logic signed [DEG_W-1:0] deg;
    logic signed [X_W-1:0]   xv;
    logic signed [OUT_W-1:0] poly;
    status_t                 st;
  } poly_word_t;

  logic clk = 1'b0;
  logic rst_n;

  lpe_in_if  in_ch ();
  lpe_out_if out_ch ();

  legendre_polynomial_eval #(
    .MAX_DEGREE (MAX_DEG),
    .FRAC_BITS  (FRAC)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  poly_word_t pending_words[$];
  int         mismatch_count = 0;
  int         cycle_count = 0;
  int         sender_gap_max = GAP_MAX;
  int         receiver_gap_max = GAP_MAX;
  int         receiver_hold_cycles = 0;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // bonnet recurrence in fixed point, every step rounded and saturated
  function automatic poly_word_t calc_legendre(input logic signed [DEG_W-1:0] deg,
                                               input logic signed [X_W-1:0] xv);
    poly_word_t r;
    longint     d, x, prev, cur, nxt, t, num, k, rc;
    r.deg  = deg;
    r.xv   = xv;
    r.poly = '0;
    r.st   = ST_OK;
    d = deg;
    x = xv;
    if (x > ONE) x = ONE;
    if (x < -ONE) x = -ONE;
    if (d < 0) begin
      r.st = ST_NEG;
    end else if (d > MAX_DEG) begin
      r.st = ST_BIG;
    end else if (d == 0) begin
      r.poly = OUT_W'(ONE);
    end else if (d == 1) begin
      r.poly = OUT_W'(x);
    end else begin
      prev = ONE;
      cur  = x;
      for (longint c = 1; c < d; c++) begin
        t   = (x * cur + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
        num = (2 * c + 1) * t - c * prev;
        k   = c + 1;
        rc  = ((longint'(1) <<< RECIP_BITS) + k / 2) / k;
        nxt = (num * rc + (longint'(1) <<< (RECIP_BITS - 1))) >>> RECIP_BITS;
        if (nxt > ONE) nxt = ONE;
        if (nxt < -ONE) nxt = -ONE;
        prev = cur;
        cur  = nxt;
      end
      r.poly = OUT_W'(cur);
    end
    return r;
  endfunction

  // entered and left at a falling edge; valid stays high when the next word follows at once
  task automatic send_word(input logic signed [DEG_W-1:0] deg,
                           input logic signed [X_W-1:0] xv);
    int gap;
    gap = (sender_gap_max > 0) ? $urandom_range(0, sender_gap_max) : 0;
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   = 1'b1;
    in_ch.degree  = deg;
    in_ch.x_value = xv;
    do @(posedge clk); while (!in_ch.ready);
    pending_words.insert(pending_words.size(), calc_legendre(deg, xv));
    @(negedge clk);
  endtask

  task automatic wait_all_results();
    in_ch.valid = 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [DEG_W-1:0] rand_degree();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return DEG_W'($urandom_range(0, 15));
    if (sel < 70) return DEG_W'($urandom_range(16, MAX_DEG));
    if (sel < 85) return DEG_W'($urandom_range(128, 255));
    return DEG_W'($urandom_range(MAX_DEG + 1, 127));
  endfunction

  function automatic logic signed [X_W-1:0] rand_x();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return X_W'(int'($urandom_range(0, 2 * ONE)) - ONE);
    if (sel < 85) return X_W'($urandom_range(0, (1 << X_W) - 1));
    case ($urandom_range(0, 5))
      0:       return X_W'(ONE);
      1:       return X_W'(-ONE);
      2:       return X_W'(ONE - 1);
      3:       return X_W'(-ONE + 1);
      4:       return X_W'(ONE + 1);
      default: return '0;
    endcase
  endfunction

  task automatic test_fixed_degrees();
    send_word(8'sd0, X_W'(12345));
    send_word(8'sd1, X_W'(ONE));
    send_word(8'sd1, X_W'(-ONE));
    send_word(8'sd2, '0);
    send_word(8'sd2, X_W'(ONE / 2));
    send_word(8'sd3, X_W'(-ONE));
    send_word(8'sd63, X_W'(ONE));
    send_word(8'sd63, X_W'(-ONE));
    send_word(8'sd63, X_W'(ONE / 3));
    // values near plus or minus one drift past the bound at high degree
    send_word(8'sd17, X_W'(ONE - 1));
    send_word(8'sd62, X_W'(-ONE + 1));
    wait_all_results();
  endtask

  task automatic test_error_degrees();
    send_word(-8'sd1, X_W'(ONE / 4));
    send_word(-8'sd128, X_W'(-ONE));
    send_word(8'sd64, X_W'(ONE));
    send_word(8'sd127, X_W'(-7));
    wait_all_results();
  endtask

  task automatic test_argument_clamp();
    send_word(8'sd1, X_W'(131071));
    send_word(8'sd1, X_W'(-131072));
    send_word(8'sd2, X_W'(ONE + 1));
    send_word(8'sd5, X_W'(-ONE - 1));
    send_word(8'sd5, X_W'(131071));
    send_word(8'sd0, X_W'(-131072));
    wait_all_results();
  endtask

  task automatic test_random_items(input int n);
    for (int i = 0; i < n; i++) send_word(rand_degree(), rand_x());
    wait_all_results();
  endtask

  task automatic test_back_to_back(input int n);
    sender_gap_max   = 0;
    receiver_gap_max = 0;
    for (int i = 0; i < n; i++) send_word(rand_degree(), rand_x());
    wait_all_results();
    sender_gap_max   = GAP_MAX;
    receiver_gap_max = GAP_MAX;
  endtask

  // receiver holds off long enough for the output register and sequencer to fill
  task automatic test_output_stall();
    sender_gap_max       = 0;
    receiver_hold_cycles = 500;
    send_word(8'sd63, rand_x());
    send_word(8'sd2, rand_x());
    send_word(8'sd0, rand_x());
    send_word(-8'sd5, rand_x());
    send_word(8'sd63, rand_x());
    send_word(8'sd70, rand_x());
    send_word(8'sd1, rand_x());
    send_word(8'sd40, rand_x());
    wait_all_results();
    sender_gap_max = GAP_MAX;
  endtask

  initial begin : result_sink
    int gap;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (receiver_hold_cycles > 0) begin
        out_ch.ready = 1'b0;
        repeat (receiver_hold_cycles) @(negedge clk);
        receiver_hold_cycles = 0;
      end
      gap = (receiver_gap_max > 0) ? $urandom_range(0, receiver_gap_max) : 0;
      if (gap > 0) begin
        out_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid && receiver_hold_cycles == 0);
    end
  end

  always @(posedge clk) begin
    poly_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected word: poly_value=%0d status=%0d",
                   out_ch.poly_value, out_ch.status);
      end else begin
        want = pending_words.pop_front();
        if (out_ch.poly_value !== want.poly || out_ch.status !== want.st) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch d=%0d x=%0d: expected poly_value=%0d status=%0d, got %0d %0d",
                     want.deg, want.xv, want.poly, want.st,
                     out_ch.poly_value, out_ch.status);
        end
      end
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.degree  = '0;
    in_ch.x_value = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_fixed_degrees();
    test_error_degrees();
    test_argument_clamp();
    test_random_items(300);
    test_back_to_back(60);
    test_output_stall();
    test_random_items(80);
    if (mismatch_count == 0 && pending_words.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
